// ===== hdl/four_queue_round_robin_drain_assert.svh =====
// Assertion helpers for the flight queue scheduler.
// Both expect clk and rst_n in the scope where they are used.
`ifndef FOUR_QUEUE_ROUND_ROBIN_DRAIN_ASSERT_SVH
`define FOUR_QUEUE_ROUND_ROBIN_DRAIN_ASSERT_SVH

// Same-cycle implication.
`define FQRR_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication.
`define FQRR_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== hdl/fqrr_pkg.sv =====
package fqrr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_FLIGHT  = 999;
    localparam int NUM_QUEUES  = 4;

    localparam int FLIGHT_W = 10;
    localparam int QUEUE_W  = 2;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    // command codes
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd2;

    // directions
    localparam logic [QUEUE_W-1:0] DIR_WEST  = 2'd0;
    localparam logic [QUEUE_W-1:0] DIR_SOUTH = 2'd1;
    localparam logic [QUEUE_W-1:0] DIR_NORTH = 2'd2;
    localparam logic [QUEUE_W-1:0] DIR_EAST  = 2'd3;
    localparam logic [QUEUE_W:0]   NO_DIRECTION = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NODIR  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIRSET = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [FLIGHT_W-1:0] flight;
        logic [QUEUE_W-1:0]  queue;
        logic                last;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [FLIGHT_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic busy;
        logic rd_pending;
    } ctrl_stat_t;

    // Round visiting order: west, north, south, east.
    function automatic logic [QUEUE_W-1:0] serve_queue(input logic [QUEUE_W-1:0] pos);
        logic [QUEUE_W-1:0] q;
        case (pos)
            2'd0:    q = DIR_WEST;
            2'd1:    q = DIR_NORTH;
            2'd2:    q = DIR_SOUTH;
            default: q = DIR_EAST;
        endcase
        return q;
    endfunction

endpackage

// ===== hdl/fqrr_if.sv =====
interface fqrr_in_if;
    logic                            valid;
    logic                            ready;
    logic [fqrr_pkg::CMD_W-1:0]      cmd;
    logic [fqrr_pkg::QUEUE_W-1:0]    direction;
    logic [fqrr_pkg::FLIGHT_W-1:0]   flight_number;

    modport source (output valid, cmd, direction, flight_number, input ready);
    modport sink   (input valid, cmd, direction, flight_number, output ready);
endinterface

interface fqrr_out_if;
    logic                            valid;
    logic                            ready;
    logic [fqrr_pkg::STATUS_W-1:0]   status;
    logic [fqrr_pkg::FLIGHT_W-1:0]   served_flight;
    logic [fqrr_pkg::QUEUE_W-1:0]    served_queue;
    logic                            last;

    modport source (output valid, status, served_flight, served_queue, last, input ready);
    modport sink   (input valid, status, served_flight, served_queue, last, output ready);
endinterface

// ===== hdl/four_queue_round_robin_drain.sv =====
// Channel   Dir  Handshake     Payload
// command   in   valid/ready   cmd[1:0], direction[1:0], flight_number[9:0]
// report    out  valid/ready   status[2:0], served_flight[9:0], served_queue[1:0], last
//
// Select and arrival requests are accepted and their report is queued at the same edge.
// A serve request holds off the next request until the head of every non-empty
// queue has been read: after the accept, the single read port of the flight
// memory yields one queue head per cycle unless a pending head waits on a full
// report queue. Reset clears pointers, fill counts and the direction; the flight
// memory is not cleared. A two-entry report queue absorbs stalls, and command
// ready drops while it is full or a serve round is in progress.
`include "four_queue_round_robin_drain_assert.svh"

module four_queue_round_robin_drain (
    input  logic        clk,
    input  logic        rst_n,
    fqrr_in_if.sink     command,
    fqrr_out_if.source  report
);

    fqrr_pkg::ram_wr_t             wr;
    fqrr_pkg::ram_rd_t             rd;
    logic [fqrr_pkg::FLIGHT_W-1:0] rd_data;
    fqrr_pkg::result_t             push;
    fqrr_pkg::ctrl_stat_t          stat;
    logic                          space;

    // Flight storage: four queues laid out back to back, one read and one
    // write per cycle, read data registered.
    fqrr_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Sequencer: decode requests, keep head pointers and fill counts,
    // walk the round and turn memory reads into served reports.
    fqrr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .space   (space),
        .rd_data (rd_data),
        .wr      (wr),
        .rd      (rd),
        .res     (push),
        .stat    (stat)
    );

    // Report queue: decouple the output stall from the sequencer.
    fqrr_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .report (report)
    );

    // Never push a report into a full queue.
    `FQRR_ASSERT_NOW(a_push_space, push.valid, space, "report pushed into full queue")
    // Only a served report may be followed by more reports of the same request.
    `FQRR_ASSERT_NOW(a_single_last, report.valid && (report.status != fqrr_pkg::ST_SERVED),
        report.last, "non-served report without last")
    // Hold a pending served head while the report queue is full.
    `FQRR_ASSERT_NEXT(a_hold_pending, stat.rd_pending && !space, stat.rd_pending,
        "pending served head lost under stall")
    // Hold off new requests for the whole serve round.
    `FQRR_ASSERT_NOW(a_busy_stall, stat.busy, !command.ready,
        "request taken during a serve round")

endmodule

// ===== hdl/fqrr_ram.sv =====
module fqrr_ram (
    input  logic                          clk,
    input  fqrr_pkg::ram_wr_t             wr,
    input  fqrr_pkg::ram_rd_t             rd,
    output logic [fqrr_pkg::FLIGHT_W-1:0] rd_data
);

    logic [fqrr_pkg::FLIGHT_W-1:0] mem [fqrr_pkg::NUM_QUEUES * fqrr_pkg::QUEUE_DEPTH];
    logic [fqrr_pkg::FLIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/fqrr_outq.sv =====
module fqrr_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  fqrr_pkg::result_t   push,
    output logic                space,
    fqrr_out_if.source          report
);

    fqrr_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              pop;
    fqrr_pkg::result_t head;

    assign pop   = report.valid && report.ready;
    assign space = (cnt_reg != 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push.valid && pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push;
        end
    end

    assign report.valid         = (cnt_reg != 2'd0);
    assign report.status        = head.status;
    assign report.served_flight = head.flight;
    assign report.served_queue  = head.queue;
    assign report.last          = head.last;

endmodule

// ===== hdl/fqrr_ctrl.sv =====
module fqrr_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    fqrr_in_if.sink                       command,
    input  logic                          space,
    input  logic [fqrr_pkg::FLIGHT_W-1:0] rd_data,
    output fqrr_pkg::ram_wr_t             wr,
    output fqrr_pkg::ram_rd_t             rd,
    output fqrr_pkg::result_t             res,
    output fqrr_pkg::ctrl_stat_t          stat
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SERVE = 1'b1;

    localparam int PTR_W  = fqrr_pkg::PTR_W;
    localparam int CNT_W  = fqrr_pkg::CNT_W;
    localparam int ADDR_W = fqrr_pkg::ADDR_W;
    localparam int NQ     = fqrr_pkg::NUM_QUEUES;

    logic                          state_reg, state_next;
    logic [PTR_W-1:0]              head_reg [NQ];
    logic [PTR_W-1:0]              head_next [NQ];
    logic [CNT_W-1:0]              fill_reg [NQ];
    logic [CNT_W-1:0]              fill_next [NQ];
    logic [fqrr_pkg::QUEUE_W:0]    dir_reg, dir_next;
    logic [NQ-1:0]                 mask_reg, mask_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [fqrr_pkg::QUEUE_W-1:0]  rd_queue_reg, rd_queue_next;
    logic                          rd_last_reg, rd_last_next;

    logic                          accept;
    logic                          issue_ok;
    logic [fqrr_pkg::QUEUE_W-1:0]  arr_q;
    logic [CNT_W:0]                slot_sum;
    logic [PTR_W-1:0]              slot;
    logic [fqrr_pkg::FLIGHT_W-1:0] flight_sat;
    logic [NQ-1:0]                 nonempty;
    logic [fqrr_pkg::QUEUE_W-1:0]  pick_pos;
    logic [fqrr_pkg::QUEUE_W-1:0]  pick_q;
    logic [NQ-1:0]                 mask_left;

    assign command.ready = (state_reg == ST_IDLE) && !rd_valid_reg && space;
    assign accept        = command.valid && command.ready;
    assign issue_ok      = !rd_valid_reg || space;

    assign stat.busy       = (state_reg == ST_SERVE);
    assign stat.rd_pending = rd_valid_reg;

    // tail slot of the selected queue
    assign arr_q    = dir_reg[fqrr_pkg::QUEUE_W-1:0];
    assign slot_sum = (CNT_W+1)'(head_reg[arr_q]) + (CNT_W+1)'(fill_reg[arr_q]);
    assign slot     = (slot_sum >= (CNT_W+1)'(fqrr_pkg::QUEUE_DEPTH))
                    ? PTR_W'(slot_sum - (CNT_W+1)'(fqrr_pkg::QUEUE_DEPTH))
                    : PTR_W'(slot_sum);

    // clamp oversize flight numbers
    assign flight_sat = (32'(command.flight_number) > fqrr_pkg::MAX_FLIGHT)
                      ? fqrr_pkg::FLIGHT_W'(fqrr_pkg::MAX_FLIGHT)
                      : command.flight_number;

    // non-empty queues, indexed by position in the round
    always_comb
    begin
        for (int i = 0; i < NQ; i++)
        begin
            nonempty[i] = (fill_reg[fqrr_pkg::serve_queue(fqrr_pkg::QUEUE_W'(i))] != '0);
        end
    end

    // first remaining position of the round
    always_comb
    begin
        pick_pos = '0;
        for (int i = NQ - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_pos = fqrr_pkg::QUEUE_W'(i);
            end
        end
        mask_left           = mask_reg;
        mask_left[pick_pos] = 1'b0;
    end

    assign pick_q = fqrr_pkg::serve_queue(pick_pos);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        dir_next      = dir_reg;
        mask_next     = mask_reg;
        rd_valid_next = rd_valid_reg;
        rd_queue_next = rd_queue_reg;
        rd_last_next  = rd_last_reg;
        res           = '0;
        wr            = '0;
        rd            = '0;

        if (accept)
        begin
            case (command.cmd)
                fqrr_pkg::CMD_SELECT:
                begin
                    dir_next   = {1'b0, command.direction};
                    res.valid  = 1'b1;
                    res.status = fqrr_pkg::ST_DIRSET;
                    res.last   = 1'b1;
                end
                fqrr_pkg::CMD_ARRIVE:
                begin
                    res.valid = 1'b1;
                    res.last  = 1'b1;
                    if (dir_reg[fqrr_pkg::QUEUE_W])
                    begin
                        res.status = fqrr_pkg::ST_NODIR;
                    end
                    else if (fill_reg[arr_q] == CNT_W'(fqrr_pkg::QUEUE_DEPTH))
                    begin
                        res.status = fqrr_pkg::ST_FULL;
                    end
                    else
                    begin
                        res.status       = fqrr_pkg::ST_STORED;
                        wr.en            = 1'b1;
                        wr.addr          = ADDR_W'(arr_q) * ADDR_W'(fqrr_pkg::QUEUE_DEPTH)
                                         + ADDR_W'(slot);
                        wr.data          = flight_sat;
                        fill_next[arr_q] = fill_reg[arr_q] + CNT_W'(1);
                    end
                end
                fqrr_pkg::CMD_SERVE:
                begin
                    if (nonempty == '0)
                    begin
                        res.valid  = 1'b1;
                        res.status = fqrr_pkg::ST_EMPTY;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        mask_next  = nonempty;
                        state_next = ST_SERVE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // read stage: deliver the popped head
        if (rd_valid_reg && space)
        begin
            res.valid     = 1'b1;
            res.status    = fqrr_pkg::ST_SERVED;
            res.flight    = rd_data;
            res.queue     = rd_queue_reg;
            res.last      = rd_last_reg;
            rd_valid_next = 1'b0;
        end

        // one queue head per cycle, unless a pending head waits on a full report queue
        if ((state_reg == ST_SERVE) && issue_ok)
        begin
            rd.en             = 1'b1;
            rd.addr           = ADDR_W'(pick_q) * ADDR_W'(fqrr_pkg::QUEUE_DEPTH)
                              + ADDR_W'(head_reg[pick_q]);
            head_next[pick_q] = (head_reg[pick_q] == PTR_W'(fqrr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : head_reg[pick_q] + PTR_W'(1);
            fill_next[pick_q] = fill_reg[pick_q] - CNT_W'(1);
            mask_next         = mask_left;
            rd_valid_next     = 1'b1;
            rd_queue_next     = pick_q;
            rd_last_next      = (mask_left == '0);
            if (mask_left == '0)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dir_reg      <= fqrr_pkg::NO_DIRECTION;
            mask_reg     <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            dir_reg      <= dir_next;
            mask_reg     <= mask_next;
            rd_valid_reg <= rd_valid_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_queue_reg <= rd_queue_next;
        rd_last_reg  <= rd_last_next;
    end

endmodule
